// ----- rtl/exl_pkg.sv -----
// Package for the expression lexer: token codes, character constants and queue entry types.
`default_nettype none

package exl_pkg;

    // Token kinds as they appear on the output.
    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_EQUAL  = 4'd2;
    localparam logic [3:0] KIND_PLUS   = 4'd3;
    localparam logic [3:0] KIND_MINUS  = 4'd4;
    localparam logic [3:0] KIND_STAR   = 4'd5;
    localparam logic [3:0] KIND_SLASH  = 4'd6;
    localparam logic [3:0] KIND_IDENT  = 4'd7;
    localparam logic [3:0] KIND_NUMBER = 4'd8;

    // Kind of the pending run.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // Default number of entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One output character with its token markers.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       first;
        logic       last;
    } t_tok;

    // All results of one input beat; tok1 is only meaningful when two is set.
    typedef struct packed {
        t_tok tok0;
        t_tok tok1;
        logic two;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/expression_lexer_top.sv -----
// Top level of the expression lexer: front end, result queue and output back end.
//
// The block tokenizes arithmetic expression text one character per input beat.
// Input channel: i_valid, i_char_in and i_end_of_text, with o_stall back to the
// sender; a beat is taken at a rising edge where i_valid is high and o_stall low.
// Output channel: o_valid and the token fields, with i_stall from the receiver;
// a beat leaves at a rising edge where o_valid is high and i_stall low.
// Each output beat is one character of a token, marked with its kind, whether it
// opens or closes the token, and o_run_last on the final beat an input caused.
// Identifier and number characters come out one input beat late, because a run
// only ends when the following character is seen. An input may cause no beat.
// With the queue empty and the output free, the first result of an input goes
// through a queue entry and then the output register to the port. One input per
// cycle is taken while the queue is not full and it yields at most one result;
// the output register sends one beat per cycle while i_stall is low, so an input
// with two results occupies the output for two beats. A queue of QUEUE_DEPTH
// entries sits between front and back, so input is taken while results wait.
// When the receiver stalls, the output beat holds and the queue fills; o_stall
// rises only when the queue is full. Synchronous reset clears the pending run,
// the stopped flag, the queue and the output valid.
`default_nettype none

module expression_lexer_top #(
    parameter int QUEUE_DEPTH = exl_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [3:0]      o_token_kind,
    output logic [7:0]      o_char_out,
    output logic            o_token_first,
    output logic            o_token_last,
    output logic            o_run_last
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    exl_pkg::t_entry w_entry;
    exl_pkg::t_entry w_head;

    // Classifier: keeps the pending run and the stopped flag, builds result entries.
    exl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_char_in     (i_char_in),
        .i_end_of_text (i_end_of_text),
        .i_full        (w_full),
        .o_stall       (o_stall),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    // Decoupling queue: each entry carries all results of one input beat.
    exl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Serializer: one or two output beats per entry through an output register.
    exl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_token_kind  (o_token_kind),
        .o_char_out    (o_char_out),
        .o_token_first (o_token_first),
        .o_token_last  (o_token_last),
        .o_run_last    (o_run_last)
    );

endmodule

`default_nettype wire

// ----- rtl/exl_front.sv -----
// Front end of the expression lexer: classifies characters, tracks the pending run.
`default_nettype none

module exl_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_char_in,
    input  wire logic              i_end_of_text,
    input  wire logic              i_full,
    output logic                   o_stall,
    output logic                   o_push,
    output exl_pkg::t_entry        o_entry
);

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c == exl_pkg::CH_UNDER);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_pending(input logic [1:0] m);
        return (m == exl_pkg::MODE_IDENT) || (m == exl_pkg::MODE_NUMBER);
    endfunction

    function automatic logic [3:0] run_kind(input logic [1:0] m);
        return (m == exl_pkg::MODE_IDENT) ? exl_pkg::KIND_IDENT : exl_pkg::KIND_NUMBER;
    endfunction

    function automatic exl_pkg::t_tok mk_tok(input logic [3:0] k, input logic [7:0] c,
                                             input logic f, input logic l);
        exl_pkg::t_tok t;
        t.kind  = k;
        t.ch    = c;
        t.first = f;
        t.last  = l;
        return t;
    endfunction

    logic [1:0]    r_mode, n_mode;
    logic [7:0]    r_held, n_held;
    logic          r_hfirst, n_hfirst;
    logic          r_stopped, n_stopped;

    logic          w_accept;
    logic          w_letter, w_digit, w_single;
    logic [3:0]    w_skind;
    logic [1:0]    v_cnt;
    exl_pkg::t_tok v_tok0, v_tok1, v_new;

    assign w_accept = i_valid & ~i_full;
    assign o_stall  = i_full;
    assign w_letter = is_letter(i_char_in);
    assign w_digit  = is_decimal(i_char_in);

    always_comb begin
        w_single = 1'b1;
        case (i_char_in)
            exl_pkg::CH_LPAREN: w_skind = exl_pkg::KIND_LPAREN;
            exl_pkg::CH_RPAREN: w_skind = exl_pkg::KIND_RPAREN;
            exl_pkg::CH_EQUAL:  w_skind = exl_pkg::KIND_EQUAL;
            exl_pkg::CH_PLUS:   w_skind = exl_pkg::KIND_PLUS;
            exl_pkg::CH_MINUS:  w_skind = exl_pkg::KIND_MINUS;
            exl_pkg::CH_STAR:   w_skind = exl_pkg::KIND_STAR;
            exl_pkg::CH_SLASH:  w_skind = exl_pkg::KIND_SLASH;
            default: begin
                w_skind  = exl_pkg::KIND_LPAREN;
                w_single = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_hfirst  = r_hfirst;
        n_stopped = r_stopped;
        v_cnt     = 2'd0;
        v_tok0    = '0;
        v_tok1    = '0;
        v_new     = '0;
        if (!r_stopped) begin
            if (i_char_in == exl_pkg::CH_DOLLAR) begin
                if (is_pending(r_mode)) begin
                    v_tok0 = mk_tok(run_kind(r_mode), r_held, r_hfirst, 1'b1);
                    v_cnt  = 2'd1;
                end
                n_mode    = exl_pkg::MODE_NONE;
                n_held    = '0;
                n_hfirst  = 1'b0;
                n_stopped = 1'b1;
            end else if (r_mode == exl_pkg::MODE_IDENT && (w_letter || w_digit)) begin
                v_tok0   = mk_tok(exl_pkg::KIND_IDENT, r_held, r_hfirst, 1'b0);
                v_cnt    = 2'd1;
                n_held   = i_char_in;
                n_hfirst = 1'b0;
            end else if (r_mode == exl_pkg::MODE_NUMBER && w_digit) begin
                v_tok0   = mk_tok(exl_pkg::KIND_NUMBER, r_held, r_hfirst, 1'b0);
                v_cnt    = 2'd1;
                n_held   = i_char_in;
                n_hfirst = 1'b0;
            end else begin
                // Anything else ends the pending run.
                if (is_pending(r_mode)) begin
                    v_tok0 = mk_tok(run_kind(r_mode), r_held, r_hfirst, 1'b1);
                    v_cnt  = 2'd1;
                end
                n_mode   = exl_pkg::MODE_NONE;
                n_held   = '0;
                n_hfirst = 1'b0;
                if (w_single) begin
                    v_new = mk_tok(w_skind, i_char_in, 1'b1, 1'b1);
                    if (v_cnt == 2'd0) begin
                        v_tok0 = v_new;
                    end else begin
                        v_tok1 = v_new;
                    end
                    v_cnt = v_cnt + 2'd1;
                end else if (w_letter) begin
                    n_mode   = exl_pkg::MODE_IDENT;
                    n_held   = i_char_in;
                    n_hfirst = 1'b1;
                end else if (w_digit) begin
                    n_mode   = exl_pkg::MODE_NUMBER;
                    n_held   = i_char_in;
                    n_hfirst = 1'b1;
                end
            end
        end
        if (i_end_of_text) begin
            if (!n_stopped && is_pending(n_mode)) begin
                v_new = mk_tok(run_kind(n_mode), n_held, n_hfirst, 1'b1);
                if (v_cnt == 2'd0) begin
                    v_tok0 = v_new;
                end else begin
                    v_tok1 = v_new;
                end
                v_cnt = v_cnt + 2'd1;
            end
            n_mode    = exl_pkg::MODE_NONE;
            n_held    = '0;
            n_hfirst  = 1'b0;
            n_stopped = 1'b0;
        end
    end

    assign o_push        = w_accept && (v_cnt != 2'd0);
    assign o_entry.tok0  = v_tok0;
    assign o_entry.tok1  = v_tok1;
    assign o_entry.two   = (v_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= exl_pkg::MODE_NONE;
            r_held    <= '0;
            r_hfirst  <= 1'b0;
            r_stopped <= 1'b0;
        end else if (w_accept) begin
            r_mode    <= n_mode;
            r_held    <= n_held;
            r_hfirst  <= n_hfirst;
            r_stopped <= n_stopped;
        end
    end

    // Once stopped, no run may be left pending.
    a_stop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_mode == exl_pkg::MODE_NONE))
        else $error("exl_front: run pending while stopped");

    // The first-character marker only lives with a pending run.
    a_first_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hfirst |-> is_pending(r_mode))
        else $error("exl_front: first marker without a pending run");

endmodule

`default_nettype wire

// ----- rtl/exl_fifo.sv -----
// Short register queue of result entries between the lexer front and back.
`default_nettype none

module exl_fifo #(
    parameter int DEPTH = exl_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire exl_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output exl_pkg::t_entry      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    exl_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("exl_fifo: push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("exl_fifo: pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/exl_back.sv -----
// Back end of the expression lexer: serializes queued results onto the output register.
`default_nettype none

module exl_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire exl_pkg::t_entry i_head,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output logic [3:0]           o_token_kind,
    output logic [7:0]           o_char_out,
    output logic                 o_token_first,
    output logic                 o_token_last,
    output logic                 o_run_last
);

    logic          r_valid;
    logic          r_slot;
    exl_pkg::t_tok r_tok;
    logic          r_rlast;
    logic          w_load;
    logic          w_take;

    assign w_load = !r_valid || !i_stall;
    assign w_take = w_load && !i_empty;
    // The entry leaves the queue with its last result.
    assign o_pop  = w_take && (r_slot || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (w_take) begin
                r_slot <= i_head.two && !r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tok   <= r_slot ? i_head.tok1 : i_head.tok0;
            r_rlast <= r_slot || !i_head.two;
        end
    end

    assign o_valid       = r_valid;
    assign o_token_kind  = r_tok.kind;
    assign o_char_out    = r_tok.ch;
    assign o_token_first = r_tok.first;
    assign o_token_last  = r_tok.last;
    assign o_run_last    = r_rlast;

    // Midway through a two-result entry, the first result is on the port.
    a_slot_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot |-> (r_valid && !r_rlast))
        else $error("exl_back: second slot pending without first result shown");

endmodule

`default_nettype wire
